// File: src/cwpm_pkg.sv
// Shared types, constants and modular helpers for the challenge word pair mixer.
// Arithmetic is modulo the Mersenne prime 2^31-1, where doubling is a 31-bit rotation.
// No dependencies.
package cwpm_pkg;

    // Field widths
    localparam int unsigned RES_W = 31;
    localparam int unsigned KEY_W = 32;

    // Modulus and the fixed scrambling multiplier
    localparam logic [RES_W-1:0] MOD_P   = 31'h7FFF_FFFF;
    localparam logic [RES_W-1:0] MIX_MUL = 31'h0E79_A9C1;

    // Digit-serial multiplier geometry: multiplier bits consumed per cycle
    localparam int unsigned DIGIT_W    = 2;
    localparam int unsigned NUM_DIGITS = (RES_W + DIGIT_W - 1) / DIGIT_W;
    localparam int unsigned SR_W       = NUM_DIGITS * DIGIT_W;
    localparam int unsigned CNT_W      = $clog2(NUM_DIGITS + 1);
    // Wide enough for DIGIT_W + 1 terms of 31 bits while DIGIT_W stays below eight
    localparam int unsigned SUM_W      = RES_W + 3;

    // Configuration register indexes
    localparam logic [1:0] KEY0_IDX = 2'd0;
    localparam logic [1:0] KEY1_IDX = 2'd1;
    localparam logic [1:0] KEY2_IDX = 2'd2;
    localparam logic [1:0] KEY3_IDX = 2'd3;

    // Request to the modular multiplier
    typedef struct packed {
        logic             start;
        logic [RES_W-1:0] a;
        logic [RES_W-1:0] b;
    } mul_req_t;

    // Answer from the modular multiplier
    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] product;
    } mul_rsp_t;

    // Reduce a 32-bit value to the canonical range [0, 2^31-2].
    function automatic logic [RES_W-1:0] mod_fold32(input logic [31:0] x);
        logic [31:0]      f;
        logic [RES_W-1:0] g;
        f = {1'b0, x[30:0]} + {31'b0, x[31]};
        g = f[30:0] + {30'b0, f[31]};
        return (g == MOD_P) ? '0 : g;
    endfunction

    // Modular sum of two 31-bit values.
    function automatic logic [RES_W-1:0] mod_add(input logic [RES_W-1:0] a,
                                                 input logic [RES_W-1:0] b);
        return mod_fold32({1'b0, a} + {1'b0, b});
    endfunction

    // Left rotation of a 31-bit value, which multiplies it by 2^amt modulo 2^31-1.
    function automatic logic [RES_W-1:0] rotl31(input logic [RES_W-1:0] x,
                                                input int unsigned     amt);
        logic [2*RES_W-1:0] dbl;
        dbl = {x, x};
        return dbl[2*RES_W-1-amt -: RES_W];
    endfunction

    // One digit step of a most-significant-first modular product:
    // acc * 2^DIGIT_W + a * digit, reduced.
    function automatic logic [RES_W-1:0] mod_digit_step(input logic [RES_W-1:0]   acc,
                                                        input logic [RES_W-1:0]   a,
                                                        input logic [DIGIT_W-1:0] digit);
        logic [SUM_W-1:0] s;
        logic [31:0]      f;
        s = {3'b0, rotl31(acc, DIGIT_W)};
        for (int unsigned j = 0; j < DIGIT_W; j++) begin
            if (digit[j]) begin
                s = s + {3'b0, rotl31(a, j)};
            end
        end
        f = {1'b0, s[RES_W-1:0]} + {29'b0, s[SUM_W-1:RES_W]};
        return mod_fold32(f);
    endfunction

endpackage

// File: src/cwpm_mul_mod.sv
// Digit-serial multiplier modulo 2^31-1, consuming the multiplier a digit per cycle.
// Depends on cwpm_pkg for the digit step, the request and answer types and sizes.
module cwpm_mul_mod (
    input  logic               clk,
    input  logic               rst_n,
    input  cwpm_pkg::mul_req_t req,
    output cwpm_pkg::mul_rsp_t rsp
);

    logic [cwpm_pkg::RES_W-1:0] acc_reg;
    logic [cwpm_pkg::RES_W-1:0] a_reg;
    logic [cwpm_pkg::SR_W-1:0]  b_sr_reg;
    logic [cwpm_pkg::CNT_W-1:0] cnt_reg;
    logic                       running_reg;
    logic                       done_reg;

    // Load on a request, then fold in one multiplier digit per cycle, top digit first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                acc_reg     <= '0;
                a_reg       <= req.a;
                b_sr_reg    <= {{(cwpm_pkg::SR_W - cwpm_pkg::RES_W){1'b0}}, req.b};
                cnt_reg     <= cwpm_pkg::CNT_W'(cwpm_pkg::NUM_DIGITS);
                running_reg <= 1'b1;
            end
            else if (running_reg)
            begin
                acc_reg  <= cwpm_pkg::mod_digit_step(
                                acc_reg, a_reg,
                                b_sr_reg[cwpm_pkg::SR_W-1 -: cwpm_pkg::DIGIT_W]);
                b_sr_reg <= b_sr_reg << cwpm_pkg::DIGIT_W;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_reg == cwpm_pkg::CNT_W'(1))
                begin
                    running_reg <= 1'b0;
                    done_reg    <= 1'b1;
                end
            end
        end
    end

    // The product sits in the accumulator during the done cycle.
    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// File: src/challenge_word_pair_mixer.sv
// Top level of the challenge word pair mixer: key registers, sequencer and accumulators.
// Depends on cwpm_pkg and instantiates cwpm_mul_mod.
//
// Usage
//   Configuration: the four key words are written through cfg_write, cfg_index and
//   cfg_data, one per cycle, by the user only while busy is low (block does not check).
//   Input: a word pair (first_word, second_word, last_pair) is taken at a rising edge
//   where start is high and busy is low. busy stays high while the pair is processed.
//   Each pair runs three modular products on one digit-serial multiplier that retires
//   two multiplier bits per cycle, with modular additions around them.
//   Output: only the last pair gives a response. The four response words are valid on
//   their ports when done is high, which it is for a single cycle.
//   The receiver cannot hold a word off; it must take it in that cycle.
//   After a result both accumulators are back at zero for the next challenge.
//   Reset: the key words and the accumulators clear to zero and the block is idle.
module challenge_word_pair_mixer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [30:0] first_word,
    input  logic [30:0] second_word,
    input  logic        last_pair,
    output logic        done,
    output logic [31:0] response_word0,
    output logic [31:0] response_word1,
    output logic [31:0] response_word2,
    output logic [31:0] response_word3
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE,
        S_TEMP,
        S_MIX,
        S_HIGH,
        S_LOW1,
        S_LOW2,
        S_FINAL
    } state_t;

    state_t state_reg;

    logic [cwpm_pkg::KEY_W-1:0] key0_reg;
    logic [cwpm_pkg::KEY_W-1:0] key1_reg;
    logic [cwpm_pkg::KEY_W-1:0] key2_reg;
    logic [cwpm_pkg::KEY_W-1:0] key3_reg;

    logic [cwpm_pkg::RES_W-1:0] high_acc_reg;
    logic [cwpm_pkg::RES_W-1:0] low_acc_reg;
    logic [cwpm_pkg::RES_W-1:0] second_reg;
    logic                       last_reg;
    logic [cwpm_pkg::RES_W-1:0] temp_reg;
    logic [cwpm_pkg::RES_W-1:0] high_reg;
    logic [cwpm_pkg::RES_W-1:0] low_reg;
    logic [cwpm_pkg::RES_W-1:0] low_next;
    logic [cwpm_pkg::RES_W-1:0] high_fin;
    logic [cwpm_pkg::RES_W-1:0] low_fin;

    logic                       done_reg;
    logic [cwpm_pkg::KEY_W-1:0] resp0_reg;
    logic [cwpm_pkg::KEY_W-1:0] resp1_reg;
    logic [cwpm_pkg::KEY_W-1:0] resp2_reg;
    logic [cwpm_pkg::KEY_W-1:0] resp3_reg;

    cwpm_pkg::mul_req_t mul_req;
    cwpm_pkg::mul_rsp_t mul_rsp;

    // Key word registers, written by index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg <= '0;
            key1_reg <= '0;
            key2_reg <= '0;
            key3_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                cwpm_pkg::KEY0_IDX: key0_reg <= cfg_data;
                cwpm_pkg::KEY1_IDX: key1_reg <= cfg_data;
                cwpm_pkg::KEY2_IDX: key2_reg <= cfg_data;
                cwpm_pkg::KEY3_IDX: key3_reg <= cfg_data;
                default:            key0_reg <= key0_reg;
            endcase
        end
    end

    // Multiplier requests: the scrambled first word, the keyed sum, then the mixed word.
    always_comb
    begin
        mul_req = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                mul_req.start = start;
                mul_req.a     = cwpm_pkg::MIX_MUL;
                mul_req.b     = first_word;
            end
            S_SCALE:
            begin
                mul_req.start = mul_rsp.done;
                mul_req.a     = key0_reg[cwpm_pkg::RES_W-1:0];
                mul_req.b     = cwpm_pkg::mod_add(mul_rsp.product, high_acc_reg);
            end
            S_MIX:
            begin
                mul_req.start = 1'b1;
                mul_req.a     = key2_reg[cwpm_pkg::RES_W-1:0];
                mul_req.b     = cwpm_pkg::mod_add(second_reg, temp_reg);
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    cwpm_mul_mod u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    // Closing additions: the new low value, and the final addends on the last pair.
    assign low_next = cwpm_pkg::mod_add(low_reg, temp_reg);
    assign high_fin = cwpm_pkg::mod_add(high_reg, key1_reg[cwpm_pkg::RES_W-1:0]);
    assign low_fin  = cwpm_pkg::mod_add(low_reg, key3_reg[cwpm_pkg::RES_W-1:0]);

    // Sequencer with accumulators and the registered response.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            high_acc_reg <= '0;
            low_acc_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        second_reg <= second_word;
                        last_reg   <= last_pair;
                        state_reg  <= S_SCALE;
                    end
                end
                S_SCALE:
                begin
                    if (mul_rsp.done)
                    begin
                        state_reg <= S_TEMP;
                    end
                end
                S_TEMP:
                begin
                    if (mul_rsp.done)
                    begin
                        temp_reg  <= cwpm_pkg::mod_add(mul_rsp.product,
                                                       key1_reg[cwpm_pkg::RES_W-1:0]);
                        state_reg <= S_MIX;
                    end
                end
                S_MIX:
                begin
                    state_reg <= S_HIGH;
                end
                S_HIGH:
                begin
                    if (mul_rsp.done)
                    begin
                        high_reg  <= cwpm_pkg::mod_add(mul_rsp.product,
                                                       key3_reg[cwpm_pkg::RES_W-1:0]);
                        state_reg <= S_LOW1;
                    end
                end
                S_LOW1:
                begin
                    low_reg   <= cwpm_pkg::mod_add(low_acc_reg, high_reg);
                    state_reg <= S_LOW2;
                end
                S_LOW2:
                begin
                    if (last_reg)
                    begin
                        low_reg   <= low_next;
                        state_reg <= S_FINAL;
                    end
                    else
                    begin
                        high_acc_reg <= high_reg;
                        low_acc_reg  <= low_next;
                        state_reg    <= S_IDLE;
                    end
                end
                S_FINAL:
                begin
                    resp0_reg    <= key0_reg ^ {1'b0, high_fin};
                    resp1_reg    <= key1_reg ^ {1'b0, low_fin};
                    resp2_reg    <= key2_reg ^ {1'b0, high_fin};
                    resp3_reg    <= key3_reg ^ {1'b0, low_fin};
                    done_reg     <= 1'b1;
                    high_acc_reg <= '0;
                    low_acc_reg  <= '0;
                    state_reg    <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign response_word0 = resp0_reg;
    assign response_word1 = resp1_reg;
    assign response_word2 = resp2_reg;
    assign response_word3 = resp3_reg;

endmodule
